// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker of the storm detector.
// No dependencies; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle, outside of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The antecedent implies the consequent in the next cycle, outside of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// The antecedent implies the consequent in the next cycle, also during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/core/isd_pkg.sv =====
// Package of the interrupt storm detector: field types, codes and constants.
// No dependencies; used by every module of the block.
package isd_pkg;

  // Width of the tick arithmetic used by the window test.
  localparam int TICK_WIDTH = 32;

  typedef enum logic [1:0] {
    CMD_INTERRUPT = 2'd0,
    CMD_POLL      = 2'd1,
    CMD_TIMER     = 2'd2,
    CMD_OFFLINE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_SUBSIDED = 2'd2
  } mode_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_STORM_WINDOW   = 2'd0;
  localparam logic [1:0] REG_STORM_THRESH   = 2'd1;
  localparam logic [1:0] REG_BACKOFF_INIT   = 2'd2;
  localparam logic [1:0] REG_QUIET_INTERVAL = 2'd3;

  // Register reset values.
  localparam logic [15:0] STORM_WINDOW_RST   = 16'd1000;
  localparam logic [7:0]  STORM_THRESH_RST   = 8'd15;
  localparam logic [15:0] BACKOFF_INIT_RST   = 16'd300;
  localparam logic [31:0] QUIET_INTERVAL_RST = 32'd30000;

  localparam logic [7:0] WCOUNT_MAX = 8'hFF;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] now;
    logic        error_logged;
    logic [31:0] requested_interval;
    logic        others_in_storm;
  } item_t;

  typedef struct packed {
    logic        storm_handled;
    logic        notify;
    logic        disable_banks;
    logic        storm_join;
    logic        storm_leave;
    logic        reenable_banks;
    logic [31:0] next_interval;
    logic [1:0]  mode;
  } result_t;

  typedef struct packed {
    logic [15:0] storm_window;
    logic [7:0]  storm_threshold;
    logic [15:0] backoff_initial;
    logic [31:0] quiet_poll_interval;
  } cfg_t;

endpackage

// ===== rtl/core/interrupt_storm_detector.sv =====
// Top level of the per-CPU corrected-error interrupt storm detector.
// Depends on isd_pkg, isd_cfg and isd_core.
//
// The block takes one command transaction per clock cycle while the input side
// does not stall, and returns exactly one result transaction for each, in order.
// A command is captured in an input register, evaluated against the storm state
// in combinational logic, and its result is captured in the output register.
// The sustained rate is one transaction per cycle while the downstream side
// does not stall; it is set by the storm state update in isd_core, which
// reads and writes the mode, window count, window start and backoff counter in
// the same cycle. The input side stalls only while a result waits in the output
// register and the downstream side stalls. The count of CPUs in storm is kept
// outside: the block pulses storm_join and storm_leave and reads others_in_storm
// with each command. Configuration registers are written through cfg_write,
// cfg_index and cfg_data and take effect for the next command; write them
// only while the block is idle.
module interrupt_storm_detector (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  isd_pkg::item_t    item_data,
  output logic              result_valid,
  input  logic              result_stall,
  output isd_pkg::result_t  result_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  isd_pkg::cfg_t     cfg;
  isd_pkg::item_t    stage_item;
  logic              stage_valid;
  logic              go;
  isd_pkg::result_t  core_res;

  // The staged command moves on whenever the output register is empty or is
  // being emptied in this cycle.
  assign go         = stage_valid && (!result_valid || !result_stall);
  assign item_stall = stage_valid && !go;

  isd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  isd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (stage_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      stage_valid <= 1'b1;
    end else if (go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result_data <= core_res;
    end
  end

endmodule

// ===== rtl/core/isd_cfg.sv =====
// Configuration register file of the interrupt storm detector.
// Depends on isd_pkg for register indexes, reset values and cfg_t.
module isd_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output isd_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.storm_window        <= isd_pkg::STORM_WINDOW_RST;
      cfg.storm_threshold     <= isd_pkg::STORM_THRESH_RST;
      cfg.backoff_initial     <= isd_pkg::BACKOFF_INIT_RST;
      cfg.quiet_poll_interval <= isd_pkg::QUIET_INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        isd_pkg::REG_STORM_WINDOW:   cfg.storm_window        <= cfg_data[15:0];
        isd_pkg::REG_STORM_THRESH:   cfg.storm_threshold     <= cfg_data[7:0];
        isd_pkg::REG_BACKOFF_INIT:   cfg.backoff_initial     <= cfg_data[15:0];
        isd_pkg::REG_QUIET_INTERVAL: cfg.quiet_poll_interval <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/isd_core.sv =====
// Storm state and per-command decision logic of the interrupt storm detector.
// Depends on isd_pkg; the state advances on each cycle in which go is high.
module isd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  isd_pkg::item_t    item,
  input  isd_pkg::cfg_t     cfg,
  output isd_pkg::result_t  res
);

  isd_pkg::mode_e                   storm_mode, storm_mode_next;
  logic [7:0]                       window_count, window_count_next;
  logic [isd_pkg::TICK_WIDTH-1:0]   window_start, window_start_next;
  logic [15:0]                      backoff_count, backoff_count_next;

  logic [isd_pkg::TICK_WIDTH-1:0]   tick_now;
  logic [isd_pkg::TICK_WIDTH-1:0]   win_diff;
  logic                             in_window;

  // The window is still open while now has not passed start plus window.
  assign tick_now  = isd_pkg::TICK_WIDTH'(item.now);
  assign win_diff  = tick_now - window_start - isd_pkg::TICK_WIDTH'(cfg.storm_window);
  assign in_window = (win_diff == '0) || win_diff[isd_pkg::TICK_WIDTH-1];

  always_comb begin
    storm_mode_next    = storm_mode;
    window_count_next  = window_count;
    window_start_next  = window_start;
    backoff_count_next = backoff_count;
    res                = '0;

    case (item.command)
      isd_pkg::CMD_INTERRUPT: begin
        if (storm_mode != isd_pkg::MODE_NONE) begin
          res.storm_handled = 1'b1;
        end else begin
          if (in_window) begin
            if (window_count != isd_pkg::WCOUNT_MAX) begin
              window_count_next = window_count + 8'd1;
            end
          end else begin
            window_count_next = 8'd1;
            window_start_next = tick_now;
          end
          if (window_count_next <= cfg.storm_threshold) begin
            res.notify = 1'b1;
          end else begin
            res.disable_banks  = 1'b1;
            res.storm_join     = 1'b1;
            res.storm_handled  = 1'b1;
            res.next_interval  = 32'(cfg.storm_window);
            storm_mode_next    = isd_pkg::MODE_ACTIVE;
            backoff_count_next = cfg.backoff_initial;
          end
        end
      end
      isd_pkg::CMD_POLL: begin
        if (storm_mode != isd_pkg::MODE_NONE) begin
          res.storm_handled = 1'b1;
          if (item.error_logged) begin
            backoff_count_next = cfg.backoff_initial;
          end else if (backoff_count != 16'd0) begin
            backoff_count_next = backoff_count - 16'd1;
          end
        end
      end
      isd_pkg::CMD_TIMER: begin
        if (storm_mode == isd_pkg::MODE_ACTIVE && backoff_count != 16'd0) begin
          res.notify        = 1'b1;
          res.next_interval = 32'(cfg.storm_window);
        end else if (storm_mode != isd_pkg::MODE_NONE) begin
          // Active storms step down to subsided, and leave entirely once
          // no other CPU is still storming.
          if (storm_mode == isd_pkg::MODE_ACTIVE) begin
            storm_mode_next = isd_pkg::MODE_SUBSIDED;
            res.storm_leave = 1'b1;
          end
          if (!item.others_in_storm) begin
            storm_mode_next    = isd_pkg::MODE_NONE;
            res.reenable_banks = 1'b1;
          end
          res.next_interval = cfg.quiet_poll_interval;
        end else begin
          res.next_interval = item.requested_interval;
        end
      end
      default: begin
        res.storm_leave = (storm_mode == isd_pkg::MODE_ACTIVE);
        storm_mode_next = isd_pkg::MODE_NONE;
      end
    endcase

    res.mode = storm_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      storm_mode    <= isd_pkg::MODE_NONE;
      window_count  <= '0;
      window_start  <= '0;
      backoff_count <= '0;
    end else if (go) begin
      storm_mode    <= storm_mode_next;
      window_count  <= window_count_next;
      window_start  <= window_start_next;
      backoff_count <= backoff_count_next;
    end
  end

endmodule

// ===== rtl/core/isd_checker.sv =====
// Port-level checker of the interrupt storm detector, bound to the top level.
// Depends on isd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isd_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input isd_pkg::result_t  result_data
);

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result_data))
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !result_valid)
  `ASSERT_IMPLY(a_join_xor_leave, clk, rst, result_valid, !(result_data.storm_join && result_data.storm_leave))
  `ASSERT_IMPLY(a_join_active, clk, rst, result_valid && result_data.storm_join, result_data.mode == isd_pkg::MODE_ACTIVE && result_data.disable_banks && result_data.storm_handled)
  `ASSERT_IMPLY(a_reenable_none, clk, rst, result_valid && result_data.reenable_banks, result_data.mode == isd_pkg::MODE_NONE)

endmodule

bind interrupt_storm_detector isd_checker u_isd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);
